// ===== design/line_substring_match_counter_core_defines.svh =====
// ----------------------------------------------------------------------------
// line substring match counter assertion macros
// concurrent checks on clk with asynchronous reset arst_n
// ----------------------------------------------------------------------------
`ifndef LINE_SUBSTRING_MATCH_COUNTER_CORE_DEFINES_SVH
`define LINE_SUBSTRING_MATCH_COUNTER_CORE_DEFINES_SVH

`ifndef SYNTH
`define LSMC_CHECK(lbl, expr) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error("lsmc check failed");
`define LSMC_CHECK_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("lsmc check failed");
`else
`define LSMC_CHECK(lbl, expr)
`define LSMC_CHECK_NEXT(lbl, ante, cons)
`endif

`endif

// ===== design/lsmc_pkg.sv =====
// ----------------------------------------------------------------------------
// lsmc_pkg
// shared types, constants and helpers of the line substring match counter
// ----------------------------------------------------------------------------
package lsmc_pkg;

	localparam int unsigned LSMC_MAX_PATTERN = 16;
	localparam int unsigned LSMC_COUNT_W     = 32;
	localparam int unsigned LSMC_LEN_W       = 5;
	localparam int unsigned LSMC_CFG_W       = 64;

	localparam logic [7:0] NEWLINE_BYTE = 8'd10;
	localparam logic [LSMC_COUNT_W-1:0] COUNT_MAX = '1;

	typedef enum logic [1:0] {
		CFG_PATTERN_LOW    = 2'd0,
		CFG_PATTERN_HIGH   = 2'd1,
		CFG_PATTERN_LENGTH = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic [7:0] byte_value;
		logic       end_of_text;
	} text_item_t;

	typedef struct packed {
		logic                    line_hit;
		logic [LSMC_COUNT_W-1:0] hit_total;
		logic [LSMC_COUNT_W-1:0] line_number;
	} line_result_t;

	// pattern byte idx out of the two 64-bit pattern words
	function automatic logic [7:0] pattern_byte(input logic [63:0] lo,
	                                            input logic [63:0] hi,
	                                            input logic [3:0]  idx);
		logic [63:0] word;
		word = idx[3] ? hi : lo;
		return word[{idx[2:0], 3'b000} +: 8];
	endfunction

endpackage

// ===== design/lsmc_stream_if.sv =====
// ----------------------------------------------------------------------------
// lsmc_stream_if
// valid/ready channel carrying one payload item per transfer
// ----------------------------------------------------------------------------
interface lsmc_stream_if #(
	parameter type item_t = logic
);
	logic  valid;
	logic  ready;
	item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== design/lsmc_cell.sv =====
// ----------------------------------------------------------------------------
// lsmc_cell
// one window position: holds a text byte, passes it on, compares the byte
// it is about to take against its pattern byte
// ----------------------------------------------------------------------------
module lsmc_cell
	import lsmc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       shift,
	input  logic       clear,
	input  logic [7:0] din,
	input  logic       din_valid,
	input  logic [7:0] pat_byte,
	input  logic       care,
	output logic [7:0] dout,
	output logic       dout_valid,
	output logic       match_term
);

	logic [7:0] byte_q;
	logic       valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (clear) begin
			valid_q <= 1'b0;
		end else if (shift) begin
			valid_q <= din_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (shift) begin
			byte_q <= din;
		end
	end

	// compare on the contents after this shift
	assign match_term = !care || (din_valid && (din == pat_byte));
	assign dout       = byte_q;
	assign dout_valid = valid_q;

endmodule

// ===== design/lsmc_result_buf.sv =====
// ----------------------------------------------------------------------------
// lsmc_result_buf
// two-entry output buffer: output register plus skid entry
// ----------------------------------------------------------------------------
module lsmc_result_buf
	import lsmc_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  line_result_t  push_data,
	output logic          has_room,
	lsmc_stream_if.source line_out
);

	line_result_t head_q;
	line_result_t skid_q;
	logic         head_valid_q;
	logic         skid_valid_q;
	logic         pop;

	assign pop      = head_valid_q && line_out.ready;
	assign has_room = !skid_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (push) begin
				head_valid_q <= 1'b1;
				if (head_valid_q && !pop) begin
					skid_valid_q <= 1'b1;
				end
			end else if (pop) begin
				if (skid_valid_q) begin
					skid_valid_q <= 1'b0;
				end else begin
					head_valid_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			if (!head_valid_q || (pop && !skid_valid_q)) begin
				head_q <= push_data;
			end else if (pop) begin
				head_q <= skid_q;
				skid_q <= push_data;
			end else begin
				skid_q <= push_data;
			end
		end else if (pop && skid_valid_q) begin
			head_q <= skid_q;
		end
	end

	assign line_out.valid = head_valid_q;
	assign line_out.data  = head_q;

endmodule

// ===== design/line_substring_match_counter_core.sv =====
// ----------------------------------------------------------------------------
// line_substring_match_counter_core
// Fixed pattern search over a byte stream, one result per text line.
//
// text_in takes one byte per transfer with an end_of_text flag; a newline
// byte or a flagged byte ends the current line. line_out gives one result
// per ended line: hit flag, saturating hit count and saturating line index.
// The pattern (up to MAX_PATTERN bytes) and its length are written through
// cfg_we / cfg_index / cfg_data; the user must write them only while no
// line result is pending, which the block does not enforce. Throughput is
// one byte per cycle: a row of MAX_PATTERN cells shifts the newest bytes of
// the line and compares all positions against the pattern in the cycle the
// byte is taken. A line's result is registered on its last byte's transfer.
// line_out has an output register and a skid entry, so text_in stays ready
// while one result waits; text_in.ready falls only when both are full.
// Reset clears the pattern, the line state and both counters; after an
// end_of_text byte the counters and line state restart at zero.
// ----------------------------------------------------------------------------
`include "line_substring_match_counter_core_defines.svh"

module line_substring_match_counter_core
	import lsmc_pkg::*;
#(
	parameter int unsigned MAX_PATTERN = LSMC_MAX_PATTERN
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [1:0]            cfg_index,
	input  logic [LSMC_CFG_W-1:0] cfg_data,
	lsmc_stream_if.sink           text_in,
	lsmc_stream_if.source         line_out
);

	logic [63:0]           pat_low_q;
	logic [63:0]           pat_high_q;
	logic [LSMC_LEN_W-1:0] pat_len_q;
	logic [LSMC_LEN_W-1:0] len_eff;

	logic                    hit_seen_q;
	logic [LSMC_COUNT_W-1:0] hit_count_q;
	logic [LSMC_COUNT_W-1:0] line_count_q;

	logic       in_fire;
	logic       is_newline;
	logic       is_last;
	logic       cell_shift;
	logic       line_clear;
	logic       window_hit;
	logic       line_hit;
	logic       has_room;

	logic [7:0]             cell_byte [MAX_PATTERN];
	logic [MAX_PATTERN-1:0] cell_valid;
	logic [MAX_PATTERN-1:0] match_terms;

	logic [LSMC_COUNT_W-1:0] hit_total;
	line_result_t            result;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_low_q  <= '0;
			pat_high_q <= '0;
			pat_len_q  <= '0;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				CFG_PATTERN_LOW:    pat_low_q  <= cfg_data[63:0];
				CFG_PATTERN_HIGH:   pat_high_q <= cfg_data[63:0];
				CFG_PATTERN_LENGTH: pat_len_q  <= cfg_data[LSMC_LEN_W-1:0];
				default: ;
			endcase
		end
	end

	assign len_eff = (pat_len_q > LSMC_LEN_W'(MAX_PATTERN)) ?
		LSMC_LEN_W'(MAX_PATTERN) : pat_len_q;

	assign text_in.ready = has_room;
	assign in_fire       = text_in.valid && has_room;
	assign is_newline    = text_in.data.byte_value == NEWLINE_BYTE;
	assign is_last       = text_in.data.end_of_text;
	assign cell_shift    = in_fire && !is_newline;
	assign line_clear    = in_fire && (is_newline || is_last);

	// window cells, cell 0 holds the newest byte
	for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
		logic [7:0]            din;
		logic                  din_valid;
		logic [LSMC_LEN_W-1:0] pat_idx;
		logic                  care;

		if (k == 0) begin : g_head
			assign din       = text_in.data.byte_value;
			assign din_valid = 1'b1;
		end else begin : g_body
			assign din       = cell_byte[k-1];
			assign din_valid = cell_valid[k-1];
		end

		// cell k lines up with pattern byte len-1-k
		assign pat_idx = len_eff - LSMC_LEN_W'(k) - LSMC_LEN_W'(1);
		assign care    = LSMC_LEN_W'(k) < len_eff;

		lsmc_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.shift      (cell_shift),
			.clear      (line_clear),
			.din        (din),
			.din_valid  (din_valid),
			.pat_byte   (pattern_byte(pat_low_q, pat_high_q, pat_idx[3:0])),
			.care       (care),
			.dout       (cell_byte[k]),
			.dout_valid (cell_valid[k]),
			.match_term (match_terms[k])
		);
	end

	assign window_hit = (len_eff != '0) && (&match_terms);
	assign line_hit   = hit_seen_q || (!is_newline && window_hit) || (len_eff == '0);
	assign hit_total  = (line_hit && (hit_count_q != COUNT_MAX)) ?
		hit_count_q + LSMC_COUNT_W'(1) : hit_count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_seen_q   <= 1'b0;
			hit_count_q  <= '0;
			line_count_q <= '0;
		end else if (in_fire) begin
			if (is_last) begin
				hit_seen_q   <= 1'b0;
				hit_count_q  <= '0;
				line_count_q <= '0;
			end else if (is_newline) begin
				hit_seen_q  <= 1'b0;
				hit_count_q <= hit_total;
				if (line_count_q != COUNT_MAX) begin
					line_count_q <= line_count_q + LSMC_COUNT_W'(1);
				end
			end else if (window_hit) begin
				hit_seen_q <= 1'b1;
			end
		end
	end

	assign result.line_hit    = line_hit;
	assign result.hit_total   = hit_total;
	assign result.line_number = line_count_q;

	lsmc_result_buf u_result_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (line_clear),
		.push_data (result),
		.has_room  (has_room),
		.line_out  (line_out)
	);

	`LSMC_CHECK(a_hits_le_lines, hit_count_q <= line_count_q)
	`LSMC_CHECK_NEXT(a_eot_restart, in_fire && is_last, (hit_count_q == '0) && (line_count_q == '0) && !hit_seen_q && (cell_valid == '0))
	`LSMC_CHECK(a_valid_thermo, $onehot({1'b0, cell_valid} + {{MAX_PATTERN{1'b0}}, 1'b1}))
	`LSMC_CHECK(a_hit_counted, !(line_clear && line_hit) || (hit_total != '0))

endmodule
